[rtl/point_segment_distance_core_macros.svh]
`ifndef POINT_SEGMENT_DISTANCE_CORE_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_CORE_MACROS_SVH

// concurrent check, switched off while reset is low
`define PSD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// concurrent check that also holds during reset
`define PSD_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

[rtl/psd_pkg.sv]
`timescale 1ns / 1ps

package psd_pkg;

    localparam int COORD_WIDTH_DEF = 24;

    typedef enum logic [1:0] {
        REGION_START    = 2'd0,
        REGION_END      = 2'd1,
        REGION_INTERIOR = 2'd2
    } region_t;

    // travels with each request down the pipeline
    typedef struct packed {
        logic    valid;
        region_t region;
    } psd_tag_t;

endpackage

[rtl/point_segment_distance_core.sv]
`timescale 1ns / 1ps
// channel   direction  handshake           fields
// request   in         start & !busy       seg_start_x/y, seg_end_x/y, point_x/y
// result    out        done (one cycle)    distance, region
//
// a request is taken every cycle; busy stays low
// the pipeline holds five geometry stages, one divider stage per quotient bit
// (2*COORD_WIDTH+2), one root stage per result bit (COORD_WIDTH+1) and the
// output register
// reset clears the valid bits only; results leave without backpressure

module point_segment_distance_core
    import psd_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] seg_start_x,
    input  logic signed [COORD_WIDTH-1:0] seg_start_y,
    input  logic signed [COORD_WIDTH-1:0] seg_end_x,
    input  logic signed [COORD_WIDTH-1:0] seg_end_y,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    output logic                          done,
    output logic        [COORD_WIDTH:0]   distance,
    output logic        [1:0]             region
);

    localparam int PW = 2 * COORD_WIDTH + 2;
    localparam int NW = 2 * PW;
    localparam int RW = COORD_WIDTH + 1;

    psd_tag_t      front_tag, div_tag, sqrt_tag;
    logic [NW-1:0] front_num;
    logic [PW-1:0] front_den;
    logic [PW-1:0] div_quo;
    logic [RW-1:0] sqrt_root;

    logic          done_reg;
    logic [RW-1:0] distance_reg;
    region_t       region_reg;

    assign busy = 1'b0;

    psd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start),
        .seg_start_x (seg_start_x),
        .seg_start_y (seg_start_y),
        .seg_end_x   (seg_end_x),
        .seg_end_y   (seg_end_y),
        .point_x     (point_x),
        .point_y     (point_y),
        .out_tag     (front_tag),
        .out_num     (front_num),
        .out_den     (front_den)
    );

    // squared distance = floor(num / den)
    psd_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (front_tag),
        .in_num  (front_num),
        .in_den  (front_den),
        .out_tag (div_tag),
        .out_quo (div_quo)
    );

    psd_sqrt #(.COORD_WIDTH(COORD_WIDTH)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (div_tag),
        .in_rad   (div_quo),
        .out_tag  (sqrt_tag),
        .out_root (sqrt_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sqrt_tag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        distance_reg <= sqrt_root;
        region_reg   <= sqrt_tag.region;
    end

    assign done     = done_reg;
    assign distance = distance_reg;
    assign region   = region_reg;

endmodule

[rtl/psd_front.sv]
`timescale 1ns / 1ps

module psd_front
    import psd_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int PW = 2 * COORD_WIDTH + 2,
    localparam int NW = 2 * PW
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] seg_start_x,
    input  logic signed [COORD_WIDTH-1:0] seg_start_y,
    input  logic signed [COORD_WIDTH-1:0] seg_end_x,
    input  logic signed [COORD_WIDTH-1:0] seg_end_y,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    output psd_tag_t                      out_tag,
    output logic        [NW-1:0]          out_num,
    output logic        [PW-1:0]          out_den
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int SW = PW + 1;
    localparam int HW = PW / 2;

    // stage 1: differences
    logic                 v1_reg;
    logic signed [DW-1:0] ax_reg, ay_reg, bx_reg, by_reg, ux_reg, uy_reg;
    logic signed [DW-1:0] ax_next, ay_next, bx_next, by_next, ux_next, uy_next;

    always_comb
    begin
        ax_next = DW'(point_x) - DW'(seg_start_x);
        ay_next = DW'(point_y) - DW'(seg_start_y);
        bx_next = DW'(seg_end_x) - DW'(seg_start_x);
        by_next = DW'(seg_end_y) - DW'(seg_start_y);
        ux_next = DW'(point_x) - DW'(seg_end_x);
        uy_next = DW'(point_y) - DW'(seg_end_y);
    end

    // stage 2: products
    logic                 v2_reg;
    logic signed [PW-1:0] axbx_reg, ayby_reg, axby_reg, aybx_reg, uxbx_reg, uyby_reg;
    logic signed [PW-1:0] axax_reg, ayay_reg, uxux_reg, uyuy_reg, bxbx_reg, byby_reg;
    logic signed [PW-1:0] axbx_next, ayby_next, axby_next, aybx_next, uxbx_next, uyby_next;
    logic signed [PW-1:0] axax_next, ayay_next, uxux_next, uyuy_next, bxbx_next, byby_next;

    always_comb
    begin
        axbx_next = ax_reg * bx_reg;
        ayby_next = ay_reg * by_reg;
        axby_next = ax_reg * by_reg;
        aybx_next = ay_reg * bx_reg;
        uxbx_next = ux_reg * bx_reg;
        uyby_next = uy_reg * by_reg;
        axax_next = ax_reg * ax_reg;
        ayay_next = ay_reg * ay_reg;
        uxux_next = ux_reg * ux_reg;
        uyuy_next = uy_reg * uy_reg;
        bxbx_next = bx_reg * bx_reg;
        byby_next = by_reg * by_reg;
    end

    // stage 3: region decision and magnitudes
    psd_tag_t             tag3_reg, tag3_next;
    logic        [PW-1:0] cmag3_reg, cmag3_next;
    logic        [PW-1:0] small3_reg, small3_next;
    logic        [PW-1:0] den3_reg, den3_next;
    logic signed [SW-1:0] dot_start, dot_end, cross_prod;
    logic        [SW-1:0] cross_abs;
    logic        [PW-1:0] sum_a, sum_u, len2;

    always_comb
    begin
        dot_start  = SW'(axbx_reg) + SW'(ayby_reg);
        // (p - e).(s - e) is the negative of this sum
        dot_end    = SW'(uxbx_reg) + SW'(uyby_reg);
        cross_prod = SW'(axby_reg) - SW'(aybx_reg);
        cross_abs  = cross_prod[SW-1] ? -cross_prod : cross_prod;
        sum_a      = $unsigned(axax_reg) + $unsigned(ayay_reg);
        sum_u      = $unsigned(uxux_reg) + $unsigned(uyuy_reg);
        len2       = $unsigned(bxbx_reg) + $unsigned(byby_reg);

        tag3_next.valid = v2_reg;
        cmag3_next      = cross_abs[PW-1:0];
        den3_next       = PW'(1);
        if (dot_start[SW-1])
        begin
            tag3_next.region = REGION_START;
            small3_next      = sum_a;
        end
        else if (!dot_end[SW-1] && dot_end != '0)
        begin
            tag3_next.region = REGION_END;
            small3_next      = sum_u;
        end
        else if (len2 == '0)
        begin
            // degenerate segment
            tag3_next.region = REGION_START;
            small3_next      = sum_a;
        end
        else
        begin
            tag3_next.region = REGION_INTERIOR;
            small3_next      = sum_a;
            den3_next        = len2;
        end
    end

    // stage 4: partial products of the squared cross product
    psd_tag_t          tag4_reg;
    logic [PW-1:0]     small4_reg, den4_reg;
    logic [PW-1:0]     hh4_reg, hl4_reg, ll4_reg;
    logic [PW-1:0]     hh4_next, hl4_next, ll4_next;

    always_comb
    begin
        hh4_next = cmag3_reg[PW-1:HW] * cmag3_reg[PW-1:HW];
        hl4_next = cmag3_reg[PW-1:HW] * cmag3_reg[HW-1:0];
        ll4_next = cmag3_reg[HW-1:0] * cmag3_reg[HW-1:0];
    end

    // stage 5: numerator and denominator for the divider
    psd_tag_t      tag5_reg;
    logic [NW-1:0] num5_reg, num5_next;
    logic [PW-1:0] den5_reg;
    logic [NW-1:0] csq;

    always_comb
    begin
        csq = (NW'(hh4_reg) << PW) + (NW'(hl4_reg) << (HW + 1)) + NW'(ll4_reg);
        num5_next = (tag4_reg.region == REGION_INTERIOR) ? csq : NW'(small4_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            tag3_reg <= '0;
            tag4_reg <= '0;
            tag5_reg <= '0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            tag3_reg <= tag3_next;
            tag4_reg <= tag3_reg;
            tag5_reg <= tag4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
        ux_reg     <= ux_next;
        uy_reg     <= uy_next;
        axbx_reg   <= axbx_next;
        ayby_reg   <= ayby_next;
        axby_reg   <= axby_next;
        aybx_reg   <= aybx_next;
        uxbx_reg   <= uxbx_next;
        uyby_reg   <= uyby_next;
        axax_reg   <= axax_next;
        ayay_reg   <= ayay_next;
        uxux_reg   <= uxux_next;
        uyuy_reg   <= uyuy_next;
        bxbx_reg   <= bxbx_next;
        byby_reg   <= byby_next;
        cmag3_reg  <= cmag3_next;
        small3_reg <= small3_next;
        den3_reg   <= den3_next;
        hh4_reg    <= hh4_next;
        hl4_reg    <= hl4_next;
        ll4_reg    <= ll4_next;
        small4_reg <= small3_reg;
        den4_reg   <= den3_reg;
        num5_reg   <= num5_next;
        den5_reg   <= den4_reg;
    end

    assign out_tag = tag5_reg;
    assign out_num = num5_reg;
    assign out_den = den5_reg;

endmodule

[rtl/psd_div.sv]
`timescale 1ns / 1ps

module psd_div
    import psd_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int PW = 2 * COORD_WIDTH + 2,
    localparam int NW = 2 * PW
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  psd_tag_t      in_tag,
    input  logic [NW-1:0] in_num,
    input  logic [PW-1:0] in_den,
    output psd_tag_t      out_tag,
    output logic [PW-1:0] out_quo
);

    // restoring division, one quotient bit per stage; the upper half of the
    // numerator is always below the denominator so PW stages suffice
    psd_tag_t      tag_reg [PW];
    logic [PW-1:0] rem_reg [PW];
    logic [PW-1:0] quo_reg [PW];
    logic [PW-1:0] den_reg [PW];

    for (genvar k = 0; k < PW; k++)
    begin : g_step
        psd_tag_t      tag_in;
        logic [PW-1:0] rem_in, quo_in, den_in;
        logic [PW:0]   trial, diff;
        logic          ge;
        logic [PW-1:0] rem_next, quo_next;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                tag_in = in_tag;
                rem_in = in_num[NW-1:PW];
                quo_in = in_num[PW-1:0];
                den_in = in_den;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                tag_in = tag_reg[k-1];
                rem_in = rem_reg[k-1];
                quo_in = quo_reg[k-1];
                den_in = den_reg[k-1];
            end
        end

        always_comb
        begin
            trial    = {rem_in, quo_in[PW-1]};
            diff     = trial - {1'b0, den_in};
            ge       = (trial >= {1'b0, den_in});
            rem_next = ge ? diff[PW-1:0] : trial[PW-1:0];
            // numerator bits shift out the top, quotient bits enter below
            quo_next = {quo_in[PW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k] <= '0;
            end
            else
            begin
                tag_reg[k] <= tag_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            quo_reg[k] <= quo_next;
            den_reg[k] <= den_in;
        end
    end

    assign out_tag = tag_reg[PW-1];
    assign out_quo = quo_reg[PW-1];

endmodule

[rtl/psd_sqrt.sv]
`timescale 1ns / 1ps

module psd_sqrt
    import psd_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int PW = 2 * COORD_WIDTH + 2,
    localparam int RW = COORD_WIDTH + 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  psd_tag_t      in_tag,
    input  logic [PW-1:0] in_rad,
    output psd_tag_t      out_tag,
    output logic [RW-1:0] out_root
);

    // digit-by-digit square root, two radicand bits per stage
    psd_tag_t      tag_reg  [RW];
    logic [PW-1:0] rad_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [RW:0]   rem_reg  [RW];

    for (genvar k = 0; k < RW; k++)
    begin : g_step
        psd_tag_t      tag_in;
        logic [PW-1:0] rad_in, rad_next;
        logic [RW-1:0] root_in, root_next;
        logic [RW:0]   rem_in, rem_next;
        logic [RW+2:0] cur, trial, diff;
        logic          ge;

        if (k == 0)
        begin : g_first
            always_comb
            begin
                tag_in  = in_tag;
                rad_in  = in_rad;
                root_in = '0;
                rem_in  = '0;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                tag_in  = tag_reg[k-1];
                rad_in  = rad_reg[k-1];
                root_in = root_reg[k-1];
                rem_in  = rem_reg[k-1];
            end
        end

        always_comb
        begin
            cur       = {rem_in, rad_in[PW-1:PW-2]};
            trial     = (RW+3)'({root_in, 2'b01});
            diff      = cur - trial;
            ge        = (cur >= trial);
            // remainder stays at most twice the partial root
            rem_next  = ge ? diff[RW:0] : cur[RW:0];
            root_next = {root_in[RW-2:0], ge};
            rad_next  = {rad_in[PW-3:0], 2'b00};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k] <= '0;
            end
            else
            begin
                tag_reg[k] <= tag_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[k]  <= rad_next;
            root_reg[k] <= root_next;
            rem_reg[k]  <= rem_next;
        end
    end

    assign out_tag  = tag_reg[RW-1];
    assign out_root = root_reg[RW-1];

endmodule

[rtl/psd_checker.sv]
`timescale 1ns / 1ps
`include "point_segment_distance_core_macros.svh"

module psd_checker
    import psd_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    localparam int LATENCY = 3 * COORD_WIDTH + 9;

    `PSD_ASSERT_NORST(a_never_busy, clk, !busy)
    `PSD_ASSERT_NORST(a_quiet_in_reset, clk, !rst_n |-> !done)
    `PSD_ASSERT(a_request_gives_result, clk, rst_n, (start && !busy) |-> ##LATENCY done)
    `PSD_ASSERT(a_result_has_request, clk, rst_n, done |-> $past(start && rst_n, LATENCY))

endmodule

bind point_segment_distance_core psd_checker #(.COORD_WIDTH(COORD_WIDTH)) u_psd_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
